FILE: hw/rtl/overwrite_ring_with_lapped_reader_top_macros.svh
// Assertion macros shared by the ring store RTL.
`ifndef OVERWRITE_RING_WITH_LAPPED_READER_TOP_MACROS_SVH
`define OVERWRITE_RING_WITH_LAPPED_READER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked property on aclk, off while aresetn is low.
`define OWR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// Implication form: when cond holds, the next cycle must satisfy conseq.
`define OWR_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);
`else
`define OWR_ASSERT(label, prop, msg)
`define OWR_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

FILE: hw/rtl/owr_pkg.sv
// Package: sizes, codes and types of the overwriting ring store.
`timescale 1ns / 1ps

package owr_pkg;

    // Ring depth; a power of two so slot = position mod DEPTH is a bit slice.
    localparam int DEPTH      = 1024;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] HALF_CNT  = CNT_W'(DEPTH / 2);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

    // Request kinds carried on s_tuser
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_GET  = 1'b1;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } owr_state_t;

endpackage

FILE: hw/rtl/overwrite_ring_with_lapped_reader_top.sv
// Top level: overwriting ring store with one lapping reader.
// Result path: push and caught-up get give their result in the cycle after accept; a reading
// get passes its word through rd_data_reg, then the output register (one synchronous RAM read).
// Throughput: one push per cycle while m_tready is high; a reading get holds off the input in ST_READ,
// set by the single RAM read port and its registered data.
// Reset (aresetn low, synchronous): write slot, write count and reader position go to 0,
// the sequencer goes idle and the output empties; ring contents stay undefined until written.
`timescale 1ns / 1ps
`include "overwrite_ring_with_lapped_reader_top_macros.svh"

module overwrite_ring_with_lapped_reader_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: reader_start
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_word
    input  logic [0:0]  s_tuser,   // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] read_word, [41:32] write_slot,
                                   // [73:42] reader_position, [79:74] zero
    output logic [1:0]  m_tuser    // [0] word_valid, [1] resynced
);

    // Ring memory
    owr_pkg::word_t mem [owr_pkg::DEPTH];

    owr_pkg::owr_state_t state_reg, state_next;
    owr_pkg::addr_t      write_index_reg, write_index_next;
    owr_pkg::cnt_t       total_writes_reg;
    owr_pkg::cnt_t       read_position_reg;
    owr_pkg::word_t      rd_data_reg;
    logic                pend_resync_reg;

    logic                out_valid_reg;
    logic [31:0]         out_word_reg;
    logic                out_word_valid_reg;
    logic                out_resync_reg;
    logic [owr_pkg::SLOT_W-1:0] out_slot_reg;
    logic [31:0]         out_pos_reg;

    logic                s_acc;
    logic                is_get;
    owr_pkg::cnt_t       lag;
    logic                lapped;
    logic                caught;
    owr_pkg::cnt_t       pos_adj;
    owr_pkg::addr_t      rd_addr;

    assign s_acc  = s_tvalid && s_tready;
    assign is_get = (s_tuser[0] == owr_pkg::MODE_GET);

    // Lag of the reader behind the write count, signed mod 2^32
    assign lag     = total_writes_reg - read_position_reg;
    assign lapped  = (lag > owr_pkg::DEPTH_CNT) && !lag[owr_pkg::CNT_W-1];
    assign caught  = !lapped && ((lag == '0) || lag[owr_pkg::CNT_W-1]);
    assign pos_adj = lapped ? (total_writes_reg - owr_pkg::DEPTH_CNT + owr_pkg::HALF_CNT)
                            : read_position_reg;
    assign rd_addr = pos_adj[owr_pkg::ADDR_W-1:0];

    // Write slot advance, wraps at DEPTH
    assign write_index_next = (write_index_reg == owr_pkg::LAST_SLOT) ? '0
                                                                     : write_index_reg + 1'b1;

    // Sequencer: next state and input ready
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            owr_pkg::ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready && is_get && !caught) begin
                    state_next = owr_pkg::ST_READ;
                end
            end
            owr_pkg::ST_READ: begin
                state_next = owr_pkg::ST_IDLE;
            end
            default: begin
                state_next = owr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= owr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Ring memory: write on push, registered read on a get that is not caught up
    always_ff @(posedge aclk) begin
        if (s_acc && !is_get) begin
            mem[write_index_reg] <= owr_pkg::word_t'(s_tdata);
        end
        if (s_acc && is_get && !caught) begin
            rd_data_reg     <= mem[rd_addr];
            pend_resync_reg <= lapped;
        end
    end

    // Pointer and count state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg   <= '0;
            total_writes_reg  <= '0;
            read_position_reg <= '0;
        end else begin
            if (s_acc && !is_get) begin
                write_index_reg  <= write_index_next;
                total_writes_reg <= total_writes_reg + 1'b1;
            end
            // reader_start also reloads the reader position
            if (cfg_we) begin
                read_position_reg <= cfg_wdata;
            end else if (s_acc && is_get) begin
                read_position_reg <= caught ? total_writes_reg : pos_adj + 1'b1;
            end
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((s_acc && !(is_get && !caught)) || state_reg == owr_pkg::ST_READ) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (state_reg == owr_pkg::ST_READ) begin
            out_word_reg       <= 32'(rd_data_reg);
            out_word_valid_reg <= 1'b1;
            out_resync_reg     <= pend_resync_reg;
            out_slot_reg       <= write_index_reg;
            out_pos_reg        <= read_position_reg;
        end else if (s_acc && !is_get) begin
            out_word_reg       <= '0;
            out_word_valid_reg <= 1'b0;
            out_resync_reg     <= 1'b0;
            out_slot_reg       <= write_index_next;
            out_pos_reg        <= read_position_reg;
        end else if (s_acc && caught) begin
            out_word_reg       <= '0;
            out_word_valid_reg <= 1'b0;
            out_resync_reg     <= 1'b0;
            out_slot_reg       <= write_index_reg;
            out_pos_reg        <= total_writes_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_pos_reg, out_slot_reg, out_word_reg};
    assign m_tuser  = {out_resync_reg, out_word_valid_reg};

    // Checks
    `OWR_ASSERT_NEXT(a_read_fills_out, state_reg == owr_pkg::ST_READ, out_valid_reg,
        "reading get did not load the output register")
    `OWR_ASSERT_NEXT(a_push_counts, s_acc && !is_get,
        total_writes_reg == $past(total_writes_reg) + 32'd1,
        "push did not bump the write count")
    `OWR_ASSERT(a_resync_reads, !out_valid_reg || !out_resync_reg || out_word_valid_reg,
        "resynced result without a word")
    `OWR_ASSERT_NEXT(a_caught_clamps, s_acc && is_get && caught && !cfg_we,
        out_valid_reg && read_position_reg == total_writes_reg,
        "caught-up get did not clamp the reader position")

endmodule

FILE: verif/overwrite_ring_with_lapped_reader_tb.sv
// Testbench for the overwriting ring store: directed edge cases, then random request traffic.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_IDLE    = 12;
    localparam int HOLD_LEN    = 300;

    // Expected result of one request, one field per result field
    typedef struct packed {
        owr_pkg::word_t             word;
        logic                       valid;
        logic                       resync;
        logic [owr_pkg::SLOT_W-1:0] slot;
        owr_pkg::cnt_t              pos;
    } ring_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    overwrite_ring_with_lapped_reader_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Ring model state
    owr_pkg::word_t ring_words [owr_pkg::DEPTH];
    bit             slot_written [owr_pkg::DEPTH];
    owr_pkg::addr_t model_slot = '0;
    owr_pkg::cnt_t  model_count = '0;
    owr_pkg::cnt_t  model_pos = '0;

    ring_result_t pending_results [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  burst = 1'b0;
    int  n_push = 0, n_read = 0, n_resync = 0, n_caught_up = 0, n_cfg = 0;

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Where a get would leave the reader; hit says whether it reads an entry
    function automatic void place_reader(output owr_pkg::cnt_t pos, output bit jumped,
                                         output bit hit);
        owr_pkg::cnt_t lag;
        pos = model_pos;
        jumped = 1'b0;
        lag = model_count - pos;
        if (lag > owr_pkg::DEPTH_CNT && !lag[owr_pkg::CNT_W-1]) begin
            pos = model_count - owr_pkg::DEPTH_CNT + owr_pkg::HALF_CNT;
            jumped = 1'b1;
            lag = model_count - pos;
        end
        hit = (lag != '0) && !lag[owr_pkg::CNT_W-1];
        if (!hit) pos = model_count;
    endfunction

    // Apply one accepted request to the model and queue its result
    function automatic void predict_request(input logic kind, input owr_pkg::word_t w);
        ring_result_t r;
        owr_pkg::cnt_t p;
        bit jumped, hit;
        r = '0;
        if (kind == owr_pkg::MODE_PUSH) begin
            ring_words[model_slot] = w;
            slot_written[model_slot] = 1'b1;
            model_slot = model_slot + 1'b1;
            model_count = model_count + 1'b1;
            n_push++;
        end else begin
            place_reader(p, jumped, hit);
            r.resync = jumped;
            if (jumped) n_resync++;
            if (hit) begin
                r.word = ring_words[p[owr_pkg::ADDR_W-1:0]];
                r.valid = 1'b1;
                p = p + 1'b1;
                n_read++;
            end else begin
                n_caught_up++;
            end
            model_pos = p;
        end
        r.slot = model_slot;
        r.pos = model_pos;
        pending_results.push_back(r);
    endfunction

    // Send one request; a get that would touch a never-written slot becomes a push
    task automatic send_request(input logic mode, input owr_pkg::word_t w);
        logic kind;
        int gap;
        owr_pkg::cnt_t p;
        bit jumped, hit;
        kind = mode;
        if (kind == owr_pkg::MODE_GET) begin
            place_reader(p, jumped, hit);
            if (hit && !slot_written[p[owr_pkg::ADDR_W-1:0]]) kind = owr_pkg::MODE_PUSH;
        end
        gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(kind, w);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Reader start register, written only while idle
    task automatic write_reader_start(input owr_pkg::cnt_t value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        model_pos = value;
        n_cfg++;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int stall;
        while (!aresetn) @(negedge aclk);
        @(negedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
            end
            stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        ring_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word = m_tdata[31:0];
            got.slot = m_tdata[41:32];
            got.pos = m_tdata[73:42];
            got.valid = m_tuser[0];
            got.resync = m_tuser[1];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: word %h valid %b resync %b slot %0d pos %h",
                             got.word, got.valid, got.resync, got.slot, got.pos);
            end else begin
                want = pending_results.pop_front();
                if (got.word !== want.word || got.valid !== want.valid ||
                    got.resync !== want.resync || got.slot !== want.slot ||
                    got.pos !== want.pos) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp word %h valid %b resync %b slot %0d pos %h",
                                 want.word, want.valid, want.resync, want.slot, want.pos);
                        $display("          got word %h valid %b resync %b slot %0d pos %h",
                                 got.word, got.valid, got.resync, got.slot, got.pos);
                    end
                end
            end
        end
    end

    // Out of reset: caught-up get, extreme words, reads, catch up again
    task automatic test_reset_state();
        send_request(owr_pkg::MODE_GET, 32'h1234_5678);
        send_request(owr_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(owr_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_GET, '0);
    endtask

    // Reader ahead of the writer is clamped back to the count
    task automatic test_reader_ahead();
        write_reader_start(model_count + 32'd7);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_PUSH, 32'hA5A5_5A5A);
        send_request(owr_pkg::MODE_GET, '0);
    endtask

    // Write past one full lap so every slot holds data
    task automatic test_fill_ring();
        repeat (owr_pkg::DEPTH + 8) send_request(owr_pkg::MODE_PUSH, $urandom());
    endtask

    // Lag boundaries: exactly DEPTH, DEPTH+1, most negative, largest positive, extremes
    task automatic test_lap_edges();
        drain_results();
        write_reader_start(model_count - owr_pkg::DEPTH_CNT);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(model_count - owr_pkg::DEPTH_CNT - 32'd1);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(model_count - 32'h8000_0000);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(model_count - 32'h7FFF_FFFF);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(32'h0000_0000);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(32'hFFFF_FFFF);
        send_request(owr_pkg::MODE_GET, '0);
        write_reader_start(model_count);
        send_request(owr_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(owr_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_GET, '0);
        send_request(owr_pkg::MODE_GET, '0);
    endtask

    // Long receiver hold-off while the sender keeps offering requests
    task automatic test_backpressure();
        drain_results();
        hold_cycles = HOLD_LEN;
        burst = 1'b1;
        repeat (48) send_request(1'($urandom_range(0, 1)), $urandom());
        burst = 1'b0;
        drain_results();
    endtask

    // Random traffic in phases, each with its own reader start and get share
    task automatic test_random_traffic();
        int get_pct;
        logic kind;
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 3))
                0: write_reader_start($urandom());
                1: write_reader_start(model_count - $urandom_range(0, 1300));
                2: write_reader_start(model_count + $urandom_range(0, 20));
                default: write_reader_start($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            endcase
            get_pct = $urandom_range(20, 80);
            burst = (phase % 3 == 2);
            repeat (50) begin
                kind = ($urandom_range(0, 99) < get_pct) ? owr_pkg::MODE_GET
                                                         : owr_pkg::MODE_PUSH;
                send_request(kind, $urandom());
            end
            burst = 1'b0;
        end
    endtask

    // Sequence
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_reset_state();
        test_reader_ahead();
        test_fill_ring();
        test_lap_edges();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (10) @(negedge aclk);
        if (pending_results.size() != 0) mismatch_count++;

        $display("covered %0d pushes, %0d reads, %0d resyncs, %0d caught-up gets",
                 n_push, n_read, n_resync, n_caught_up);
        $display("%0d reader_start writes, %0d mismatches, %0d cycles",
                 n_cfg, mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/owr_pkg.sv
hw/rtl/overwrite_ring_with_lapped_reader_top.sv
verif/overwrite_ring_with_lapped_reader_tb.sv
